[rtl/esc_telemetry_frame_parser_macros.svh]
// Assertion macros used by the checker file.
`ifndef ESC_TELEMETRY_FRAME_PARSER_MACROS_SVH
`define ESC_TELEMETRY_FRAME_PARSER_MACROS_SVH

// Checked at every rising edge outside reset.
`define ETFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ETFP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/etfp_pkg.sv]
package etfp_pkg;

	localparam int FRAME_BYTES = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam int VOLTS_LO   = 0;
	localparam int TEMP_LO    = 2;
	localparam int AMPS_LO    = 4;
	localparam int ERPM_LO    = 8;
	localparam int IN_PWM_LO  = 12;
	localparam int OUT_PWM_LO = 14;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_restart;
	} in_word_t;

	typedef struct packed {
		logic [15:0] volts_raw;
		logic [15:0] temp_raw;
		logic [15:0] amps_raw;
		logic [31:0] erpm_raw;
		logic [15:0] in_pwm_raw;
		logic [15:0] out_pwm_raw;
		logic [15:0] check_word;
	} field_set_t;

	typedef struct packed {
		logic       ok;
		field_set_t fields;
	} frame_rec_t;

	typedef struct packed {
		logic        frame_ok;
		logic [15:0] volts_raw;
		logic [15:0] temp_raw;
		logic [15:0] amps_raw;
		logic [31:0] erpm_raw;
		logic [15:0] in_pwm_raw;
		logic [15:0] out_pwm_raw;
		logic [15:0] check_word;
	} out_word_t;

endpackage

[rtl/etfp_front.sv]
module etfp_front #(
	parameter int FRAME_BYTES = etfp_pkg::FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  etfp_pkg::in_word_t  item,
	output logic                q_push,
	output etfp_pkg::frame_rec_t q_rec,
	input  logic                q_full
);

	localparam int POS_W    = $clog2(FRAME_BYTES);
	localparam int LAST_POS = FRAME_BYTES - 1;
	localparam int SUM_END  = FRAME_BYTES - 2;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_eff;
	logic [7:0]       sum_a_q, sum_b_q;
	logic [7:0]       a_base, b_base, sum_a_nx, sum_b_nx;
	logic [7:0]       store_q [FRAME_BYTES];
	logic [7:0]       calc_hi, calc_lo;
	logic [15:0]      recv;
	logic             accept, is_last, in_sum;

	assign full    = q_full;
	assign accept  = push & ~q_full;
	assign pos_eff = item.frame_restart ? '0 : pos_q;
	assign is_last = (pos_eff == POS_W'(LAST_POS));
	assign in_sum  = (pos_eff < POS_W'(SUM_END));

	always_comb begin
		a_base   = (pos_eff == '0) ? 8'd0 : sum_a_q;
		b_base   = (pos_eff == '0) ? 8'd0 : sum_b_q;
		sum_a_nx = a_base + item.rx_byte;
		sum_b_nx = b_base + sum_a_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (accept) begin
			pos_q <= is_last ? '0 : pos_eff + POS_W'(1);
			if (in_sum) begin
				sum_a_q <= sum_a_nx;
				sum_b_q <= sum_b_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q[pos_eff] <= item.rx_byte;
		end
	end

	// The last byte is still on the input, so the high check byte comes from there.
	always_comb begin
		calc_hi = sum_a_q - sum_b_q;
		calc_lo = sum_b_q - {sum_a_q[6:0], 1'b0};
		recv    = {item.rx_byte, store_q[SUM_END]};
		q_rec.ok                 = ({calc_hi, calc_lo} == recv);
		q_rec.fields.volts_raw   = {store_q[etfp_pkg::VOLTS_LO + 1], store_q[etfp_pkg::VOLTS_LO]};
		q_rec.fields.temp_raw    = {store_q[etfp_pkg::TEMP_LO + 1], store_q[etfp_pkg::TEMP_LO]};
		q_rec.fields.amps_raw    = {store_q[etfp_pkg::AMPS_LO + 1], store_q[etfp_pkg::AMPS_LO]};
		q_rec.fields.erpm_raw    = {store_q[etfp_pkg::ERPM_LO + 3], store_q[etfp_pkg::ERPM_LO + 2],
			store_q[etfp_pkg::ERPM_LO + 1], store_q[etfp_pkg::ERPM_LO]};
		q_rec.fields.in_pwm_raw  = {store_q[etfp_pkg::IN_PWM_LO + 1],
			store_q[etfp_pkg::IN_PWM_LO]};
		q_rec.fields.out_pwm_raw = {store_q[etfp_pkg::OUT_PWM_LO + 1],
			store_q[etfp_pkg::OUT_PWM_LO]};
		q_rec.fields.check_word  = recv;
	end

	assign q_push = accept & is_last;

endmodule

[rtl/etfp_queue.sv]
module etfp_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = etfp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/etfp_back.sv]
module etfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  etfp_pkg::frame_rec_t q_rec,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output etfp_pkg::out_word_t  result
);

	etfp_pkg::field_set_t held_q;
	etfp_pkg::field_set_t sel;
	etfp_pkg::out_word_t  out_q;
	etfp_pkg::out_word_t  out_d;
	logic                 out_valid_q;
	logic                 load;

	assign load  = ~q_empty & (~out_valid_q | pop);
	assign q_pop = load;
	assign empty = ~out_valid_q;

	// A failed frame reports the fields of the last frame that passed, or zeros if none has passed since reset.
	always_comb begin
		sel               = q_rec.ok ? q_rec.fields : held_q;
		out_d.frame_ok    = q_rec.ok;
		out_d.volts_raw   = sel.volts_raw;
		out_d.temp_raw    = sel.temp_raw;
		out_d.amps_raw    = sel.amps_raw;
		out_d.erpm_raw    = sel.erpm_raw;
		out_d.in_pwm_raw  = sel.in_pwm_raw;
		out_d.out_pwm_raw = sel.out_pwm_raw;
		out_d.check_word  = sel.check_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else begin
			out_valid_q <= load | (out_valid_q & ~pop);
			if (load && q_rec.ok) begin
				held_q <= q_rec.fields;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= out_d;
		end
	end

	assign result = out_q;

endmodule

[rtl/esc_telemetry_frame_parser.sv]
// Channel  | Valid side | Flow control | Word
// input    | push       | full         | item   (etfp_pkg::in_word_t)
// result   | !empty     | pop          | result (etfp_pkg::out_word_t)
//
// One byte is accepted per cycle while full is low; every last byte of a
// frame yields one result. A result passes through the frame queue and the
// output register before it shows on the ports, and up to QUEUE_DEPTH results
// plus one can wait. full is high exactly when the frame queue is full.
// Reset clears position, sums, held fields, queue and result valid flag at once.
module esc_telemetry_frame_parser #(
	parameter int FRAME_BYTES = etfp_pkg::FRAME_BYTES,
	parameter int QUEUE_DEPTH = etfp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  etfp_pkg::in_word_t  item,
	input  logic                pop,
	output logic                empty,
	output etfp_pkg::out_word_t result
);

	localparam int REC_W = $bits(etfp_pkg::frame_rec_t);

	etfp_pkg::frame_rec_t front_rec;
	logic [REC_W-1:0]     q_rd_bits;
	logic                 q_push, q_full, q_pop, q_empty;

	etfp_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.q_push(q_push),
		.q_rec (front_rec),
		.q_full(q_full)
	);

	etfp_queue #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(REC_W'(front_rec)),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_data(q_rd_bits),
		.empty  (q_empty)
	);

	etfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_rec  (etfp_pkg::frame_rec_t'(q_rd_bits)),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

[rtl/etfp_checker.sv]
`include "esc_telemetry_frame_parser_macros.svh"

module etfp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input etfp_pkg::in_word_t  item,
	input logic                pop,
	input logic                empty,
	input etfp_pkg::out_word_t result
);

	`ETFP_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (empty && !full), "reset must leave no word")
	`ETFP_ASSERT(a_full_implies_result, full |-> !empty, "input stalled with no result waiting")
	`ETFP_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(result)), "result moved")
	`ETFP_ASSERT(a_no_push_drop, (push && full) |=> !(push && full && $stable(item)) || !empty, "lost word")

endmodule

bind esc_telemetry_frame_parser etfp_checker u_chk (.*);

[dv/esc_telemetry_frame_parser_tb.sv]
`timescale 1ns / 1ps

module esc_telemetry_frame_parser_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1100;
	localparam int CALM_ITEMS = 250;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	etfp_pkg::in_word_t   item;
	logic                 pop;
	logic                 empty;
	etfp_pkg::out_word_t  result;

	etfp_pkg::out_word_t  expected_frames[$];
	int         mismatch_count;
	int         bytes_sent;
	int         cycle_count;
	int         hold_request;
	bit         calm_phase;

	// Shadow of the parser state.
	logic [4:0] shadow_pos;
	logic [7:0] shadow_sum_a;
	logic [7:0] shadow_sum_b;
	logic [7:0] shadow_frame[etfp_pkg::FRAME_BYTES];
	etfp_pkg::field_set_t shadow_held;

	logic [7:0] tx_frame[etfp_pkg::FRAME_BYTES];

	esc_telemetry_frame_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic logic [15:0] shadow_pair(input int lo);
		return {shadow_frame[lo + 1], shadow_frame[lo]};
	endfunction

	task automatic predict_parser_byte(input etfp_pkg::in_word_t w);
		logic [7:0]  hi;
		logic [7:0]  lo;
		logic [15:0] recv;
		etfp_pkg::out_word_t exp_word;
		if (w.frame_restart || shadow_pos >= etfp_pkg::FRAME_BYTES) begin
			shadow_pos = '0;
		end
		if (shadow_pos == 0) begin
			shadow_sum_a = '0;
			shadow_sum_b = '0;
		end
		shadow_frame[shadow_pos] = w.rx_byte;
		if (shadow_pos < etfp_pkg::FRAME_BYTES - 2) begin
			shadow_sum_a = shadow_sum_a + w.rx_byte;
			shadow_sum_b = shadow_sum_b + shadow_sum_a;
		end
		if (shadow_pos != etfp_pkg::FRAME_BYTES - 1) begin
			shadow_pos = shadow_pos + 5'd1;
		end else begin
			shadow_pos = '0;
			hi = shadow_sum_a - shadow_sum_b;
			lo = shadow_sum_b - {shadow_sum_a[6:0], 1'b0};
			recv = shadow_pair(etfp_pkg::FRAME_BYTES - 2);
			exp_word.frame_ok = ({hi, lo} == recv);
			if (exp_word.frame_ok) begin
				shadow_held.volts_raw   = shadow_pair(etfp_pkg::VOLTS_LO);
				shadow_held.temp_raw    = shadow_pair(etfp_pkg::TEMP_LO);
				shadow_held.amps_raw    = shadow_pair(etfp_pkg::AMPS_LO);
				shadow_held.erpm_raw    = {shadow_pair(etfp_pkg::ERPM_LO + 2),
					shadow_pair(etfp_pkg::ERPM_LO)};
				shadow_held.in_pwm_raw  = shadow_pair(etfp_pkg::IN_PWM_LO);
				shadow_held.out_pwm_raw = shadow_pair(etfp_pkg::OUT_PWM_LO);
				shadow_held.check_word  = recv;
			end
			exp_word.volts_raw   = shadow_held.volts_raw;
			exp_word.temp_raw    = shadow_held.temp_raw;
			exp_word.amps_raw    = shadow_held.amps_raw;
			exp_word.erpm_raw    = shadow_held.erpm_raw;
			exp_word.in_pwm_raw  = shadow_held.in_pwm_raw;
			exp_word.out_pwm_raw = shadow_held.out_pwm_raw;
			exp_word.check_word  = shadow_held.check_word;
			expected_frames.push_back(exp_word);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic restart);
		etfp_pkg::in_word_t w;
		w.rx_byte = b;
		w.frame_restart = restart;
		if (!calm_phase && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_parser_byte(w);
		bytes_sent++;
	endtask

	task automatic fill_payload(input logic [7:0] fixed_value, input bit use_fixed);
		for (int i = 0; i < etfp_pkg::FRAME_BYTES - 2; i++) begin
			if (use_fixed) begin
				tx_frame[i] = fixed_value;
			end else begin
				case ($urandom_range(0, 9))
					0: tx_frame[i] = 8'h00;
					1: tx_frame[i] = 8'hFF;
					default: tx_frame[i] = 8'($urandom_range(0, 255));
				endcase
			end
		end
	endtask

	task automatic seal_frame();
		logic [7:0] a;
		logic [7:0] b;
		a = '0;
		b = '0;
		for (int i = 0; i < etfp_pkg::FRAME_BYTES - 2; i++) begin
			a = a + tx_frame[i];
			b = b + a;
		end
		tx_frame[etfp_pkg::FRAME_BYTES - 2] = b - {a[6:0], 1'b0};
		tx_frame[etfp_pkg::FRAME_BYTES - 1] = a - b;
	endtask

	task automatic send_frame(input int length, input logic restart_first);
		for (int i = 0; i < length; i++) begin
			send_byte(tx_frame[i], (i == 0) ? restart_first : 1'b0);
		end
	endtask

	task automatic wait_for_results();
		push <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic report_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s expected %h actual %h", $time, field, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input etfp_pkg::out_word_t got);
		etfp_pkg::out_word_t exp_word;
		if (expected_frames.size() == 0) begin
			$display("%0t unexpected word expected none actual %h", $time, got);
			mismatch_count++;
		end else begin
			exp_word = expected_frames.pop_front();
			report_field("frame_ok", 32'(exp_word.frame_ok), 32'(got.frame_ok));
			report_field("volts_raw", 32'(exp_word.volts_raw), 32'(got.volts_raw));
			report_field("temp_raw", 32'(exp_word.temp_raw), 32'(got.temp_raw));
			report_field("amps_raw", 32'(exp_word.amps_raw), 32'(got.amps_raw));
			report_field("erpm_raw", exp_word.erpm_raw, got.erpm_raw);
			report_field("in_pwm_raw", 32'(exp_word.in_pwm_raw), 32'(got.in_pwm_raw));
			report_field("out_pwm_raw", 32'(exp_word.out_pwm_raw), 32'(got.out_pwm_raw));
			report_field("check_word", 32'(exp_word.check_word), 32'(got.check_word));
		end
	endtask

	initial begin
		int stall_left;
		int idle_left;
		stall_left = 0;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				pop <= 1'b0;
			end else begin
				if (pop && !empty) begin
					check_result(result);
				end
				if (hold_request != 0) begin
					stall_left = hold_request;
					hold_request = 0;
				end
				if (stall_left > 0) begin
					stall_left--;
					pop <= 1'b0;
				end else if (calm_phase) begin
					pop <= 1'b1;
				end else if (idle_left > 0) begin
					idle_left--;
					pop <= 1'b0;
				end else if ($urandom_range(0, 5) == 0) begin
					idle_left = $urandom_range(0, 2);
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	task automatic test_failed_frame_before_any_good();
		fill_payload(8'hFF, 1'b1);
		tx_frame[etfp_pkg::FRAME_BYTES - 2] = 8'hFF;
		tx_frame[etfp_pkg::FRAME_BYTES - 1] = 8'hFF;
		send_frame(etfp_pkg::FRAME_BYTES, 1'b1);
	endtask

	task automatic test_restart_mid_frame();
		fill_payload(8'h00, 1'b0);
		send_frame(3, 1'b1);
		fill_payload(8'hFF, 1'b1);
		seal_frame();
		send_frame(etfp_pkg::FRAME_BYTES, 1'b1);
	endtask

	task automatic test_wrap_without_restart();
		fill_payload(8'h00, 1'b1);
		seal_frame();
		send_frame(etfp_pkg::FRAME_BYTES, 1'b0);
	endtask

	task automatic test_failed_frame_keeps_fields();
		fill_payload(8'h00, 1'b0);
		seal_frame();
		tx_frame[etfp_pkg::FRAME_BYTES - 1] = tx_frame[etfp_pkg::FRAME_BYTES - 1] ^ 8'h80;
		send_frame(etfp_pkg::FRAME_BYTES, 1'b0);
	endtask

	task automatic test_backpressure();
		hold_request = 400;
		for (int f = 0; f < 10; f++) begin
			fill_payload(8'h00, 1'b0);
			seal_frame();
			send_frame(etfp_pkg::FRAME_BYTES, 1'b1);
		end
	endtask

	task automatic test_drain_pause();
		for (int f = 0; f < 3; f++) begin
			fill_payload(8'h00, 1'b0);
			seal_frame();
			send_frame(etfp_pkg::FRAME_BYTES, 1'b0);
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int  target;
		int  kind;
		bit  aligned;
		target = bytes_sent + RANDOM_ITEMS;
		aligned = 1'b1;
		while (bytes_sent < target) begin
			if (bytes_sent > target - CALM_ITEMS) begin
				calm_phase = 1'b1;
			end
			kind = $urandom_range(0, 19);
			fill_payload(8'h00, 1'b0);
			seal_frame();
			if (kind < 14) begin
				send_frame(etfp_pkg::FRAME_BYTES, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (kind < 17) begin
				tx_frame[$urandom_range(0, etfp_pkg::FRAME_BYTES - 1)] ^=
					8'(1 << $urandom_range(0, 7));
				send_frame(etfp_pkg::FRAME_BYTES, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
				aligned = 1'b1;
			end else if (kind < 19) begin
				send_frame($urandom_range(1, etfp_pkg::FRAME_BYTES - 1), 1'b1);
				aligned = 1'b0;
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
				end
				aligned = 1'b0;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		mismatch_count = 0;
		bytes_sent = 0;
		hold_request = 0;
		calm_phase = 1'b0;
		shadow_pos = '0;
		shadow_sum_a = '0;
		shadow_sum_b = '0;
		shadow_held = '0;
		for (int i = 0; i < etfp_pkg::FRAME_BYTES; i++) begin
			shadow_frame[i] = '0;
			tx_frame[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_failed_frame_before_any_good();
		test_restart_mid_frame();
		test_wrap_without_restart();
		test_failed_frame_keeps_fields();
		test_backpressure();
		test_drain_pause();
		test_random_traffic();

		push <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
